// File: src/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants of the WAV stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_item;

    typedef enum logic [1:0] {
        KIND_FORMAT = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_EMPTY  = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_BAD_TAG = 3'd1,
        ERR_NO_FMT  = 3'd2,
        ERR_NO_DATA = 3'd3,
        ERR_DEPTH   = 3'd4
    } t_err;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] sample_word;
        logic               sample_is_float;
        logic               end_of_data;
        logic [15:0]        format_code;
        logic [15:0]        channel_count;
        logic [31:0]        rate_hz;
        logic [15:0]        sample_bits;
        t_err               error_code;
    } t_out_item;

    typedef enum logic [3:0] {
        PH_RIFF_TAG  = 4'd0,
        PH_RIFF_SIZE = 4'd1,
        PH_WAVE_TAG  = 4'd2,
        PH_ID1       = 4'd3,
        PH_SIZE1     = 4'd4,
        PH_SKIP1     = 4'd5,
        PH_FMT_BODY  = 4'd6,
        PH_FMT_EXTRA = 4'd7,
        PH_ID2       = 4'd8,
        PH_SIZE2     = 4'd9,
        PH_SKIP2     = 4'd10,
        PH_DATA      = 4'd11,
        PH_DONE      = 4'd12,
        PH_HALT      = 4'd13
    } t_phase;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] RST_FORMAT   = 16'd1;
    localparam logic [15:0] RST_CHANNELS = 16'd1;
    localparam logic [31:0] RST_RATE     = 32'd44100;
    localparam logic [15:0] RST_BITS     = 16'd16;

    localparam logic [15:0] FMT_FLOAT    = 16'd3;
    localparam logic [32:0] FMT_BODY_LEN = 33'd16;

endpackage

`default_nettype wire

// File: src/wsp_in_reg.sv
// ----------------------------------------------------------------------------
// wsp_in_reg
// Input register: holds one accepted byte until the parser core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsp_in_reg
    import wsp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_in_item      o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: src/wsp_core.sv
// ----------------------------------------------------------------------------
// wsp_core
// Parser state and per-byte next-state logic; forms at most one result a byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsp_core
    import wsp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_res_valid,
    input  wire logic     i_res_ready,
    output t_out_item     o_res
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_idx, n_idx;
    logic [31:0] r_tag, n_tag;
    logic [32:0] r_cr, n_cr;
    logic [15:0] r_fmt, n_fmt;
    logic [15:0] r_ch, n_ch;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic [31:0] r_asm, n_asm;
    logic        r_fmt_seen, n_fmt_seen;

    logic        fire;
    logic        has_res;
    logic        sample_now;
    logic [7:0]  b;
    logic [2:0]  bps;
    logic [3:0]  idx_inc;
    logic [31:0] size;
    t_kind       kind;
    t_err        err;
    logic [31:0] word;
    logic        isf;
    logic        eod;

    assign fire    = i_valid && i_res_ready;
    assign o_ready = i_res_ready;
    assign b       = i_item.data_byte;
    assign idx_inc = r_idx + 4'd1;

    always_comb begin
        case (r_bits)
            16'd16:  bps = 3'd2;
            16'd24:  bps = 3'd3;
            16'd32:  bps = 3'd4;
            default: bps = 3'd0;
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_tag      = r_tag;
        n_cr       = r_cr;
        n_fmt      = r_fmt;
        n_ch       = r_ch;
        n_rate     = r_rate;
        n_bits     = r_bits;
        n_asm      = r_asm;
        n_fmt_seen = r_fmt_seen;
        has_res    = 1'b0;
        sample_now = 1'b0;
        kind       = KIND_FORMAT;
        err        = ERR_NONE;
        word       = 32'd0;
        isf        = 1'b0;
        eod        = 1'b0;
        size       = 32'd0;

        case (r_phase)
            PH_RIFF_TAG, PH_WAVE_TAG, PH_ID1, PH_ID2: begin
                n_tag = {r_tag[23:0], b};
                n_idx = idx_inc;
                if (idx_inc == 4'd4) begin
                    n_idx = 4'd0;
                    n_cr  = 33'd0;
                    if (r_phase == PH_RIFF_TAG) begin
                        if (n_tag != TAG_RIFF) begin
                            has_res = 1'b1;
                            kind    = KIND_ERROR;
                            err     = ERR_BAD_TAG;
                            n_phase = PH_HALT;
                        end else begin
                            n_phase = PH_RIFF_SIZE;
                        end
                    end else if (r_phase == PH_WAVE_TAG) begin
                        if (n_tag != TAG_WAVE) begin
                            has_res = 1'b1;
                            kind    = KIND_ERROR;
                            err     = ERR_BAD_TAG;
                            n_phase = PH_HALT;
                        end else begin
                            n_phase = PH_ID1;
                        end
                    end else begin
                        n_phase = (r_phase == PH_ID1) ? PH_SIZE1 : PH_SIZE2;
                    end
                end
            end
            PH_RIFF_SIZE, PH_SIZE1, PH_SIZE2: begin
                n_cr  = {1'b0, b[7:1], b[0] | r_cr[32], r_cr[31:8]};
                n_idx = idx_inc;
                if (idx_inc == 4'd4) begin
                    size  = n_cr[31:0];
                    n_idx = 4'd0;
                    if (r_phase == PH_RIFF_SIZE) begin
                        n_cr    = 33'd0;
                        n_phase = PH_WAVE_TAG;
                    end else if (r_phase == PH_SIZE1 && r_tag == TAG_FMT) begin
                        n_fmt_seen = 1'b1;
                        n_cr = ({1'b0, size} > FMT_BODY_LEN) ?
                               {1'b0, size} - FMT_BODY_LEN : 33'd0;
                        n_phase = PH_FMT_BODY;
                    end else if (r_phase == PH_SIZE2 && r_tag == TAG_DATA) begin
                        n_cr = {1'b0, size};
                        if (bps == 3'd0) begin
                            has_res = 1'b1;
                            kind    = KIND_ERROR;
                            err     = ERR_DEPTH;
                            n_phase = PH_HALT;
                        end else if (size < {29'd0, bps}) begin
                            has_res = 1'b1;
                            kind    = KIND_EMPTY;
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end else begin
                        n_cr = {1'b0, size} + {32'd0, size[0]};
                        if (n_cr != 33'd0) begin
                            n_phase = (r_phase == PH_SIZE1) ? PH_SKIP1 : PH_SKIP2;
                        end else begin
                            n_phase = (r_phase == PH_SIZE1) ? PH_ID1 : PH_ID2;
                        end
                    end
                end
            end
            PH_SKIP1, PH_SKIP2, PH_FMT_EXTRA: begin
                if (r_cr != 33'd0) begin
                    n_cr = r_cr - 33'd1;
                end
                if (n_cr == 33'd0) begin
                    n_phase = (r_phase == PH_SKIP1) ? PH_ID1 : PH_ID2;
                end
            end
            PH_FMT_BODY: begin
                case (r_idx)
                    4'd0:    n_fmt  = {r_fmt[15:8], b};
                    4'd1:    n_fmt  = {b, r_fmt[7:0]};
                    4'd2:    n_ch   = {r_ch[15:8], b};
                    4'd3:    n_ch   = {b, r_ch[7:0]};
                    4'd4:    n_rate = {r_rate[31:8], b};
                    4'd5:    n_rate = {r_rate[31:16], b, r_rate[7:0]};
                    4'd6:    n_rate = {r_rate[31:24], b, r_rate[15:0]};
                    4'd7:    n_rate = {b, r_rate[23:0]};
                    4'd14:   n_bits = {r_bits[15:8], b};
                    4'd15:   n_bits = {b, r_bits[7:0]};
                    default: n_fmt  = r_fmt;
                endcase
                n_idx = idx_inc;
                if (r_idx == 4'd15) begin
                    has_res = 1'b1;
                    kind    = KIND_FORMAT;
                    n_phase = (r_cr != 33'd0) ? PH_FMT_EXTRA : PH_ID2;
                end
            end
            PH_DATA: begin
                if (bps == 3'd0) begin
                    n_phase = PH_HALT;
                end else begin
                    n_asm = (r_idx == 4'd0) ? {b, 24'd0} : {b, r_asm[31:8]};
                    if (r_cr != 33'd0) begin
                        n_cr = r_cr - 33'd1;
                    end
                    n_idx = idx_inc;
                    if (idx_inc >= {1'b0, bps}) begin
                        n_idx      = 4'd0;
                        has_res    = 1'b1;
                        kind       = KIND_SAMPLE;
                        sample_now = 1'b1;
                        word       = n_asm;
                        isf        = (r_fmt == FMT_FLOAT) && (bps == 3'd4);
                        if (n_cr < {30'd0, bps}) begin
                            eod     = 1'b1;
                            n_phase = PH_DONE;
                        end
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (i_item.stream_end) begin
            if (n_phase <= PH_SKIP2) begin
                has_res = 1'b1;
                kind    = KIND_ERROR;
                word    = 32'd0;
                isf     = 1'b0;
                eod     = 1'b0;
                if (n_phase <= PH_WAVE_TAG) begin
                    err = ERR_BAD_TAG;
                end else if (n_phase <= PH_FMT_EXTRA && !n_fmt_seen) begin
                    err = ERR_NO_FMT;
                end else begin
                    err = ERR_NO_DATA;
                end
            end else if (sample_now) begin
                eod = 1'b1;
            end
            n_phase    = PH_RIFF_TAG;
            n_idx      = 4'd0;
            n_tag      = 32'd0;
            n_cr       = 33'd0;
            n_asm      = 32'd0;
            n_fmt_seen = 1'b0;
        end
    end

    assign o_res_valid           = fire && has_res;
    assign o_res.kind            = kind;
    assign o_res.sample_word     = word;
    assign o_res.sample_is_float = isf;
    assign o_res.end_of_data     = eod;
    assign o_res.format_code     = n_fmt;
    assign o_res.channel_count   = n_ch;
    assign o_res.rate_hz         = n_rate;
    assign o_res.sample_bits     = n_bits;
    assign o_res.error_code      = err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_RIFF_TAG;
            r_idx      <= 4'd0;
            r_tag      <= 32'd0;
            r_cr       <= 33'd0;
            r_fmt      <= RST_FORMAT;
            r_ch       <= RST_CHANNELS;
            r_rate     <= RST_RATE;
            r_bits     <= RST_BITS;
            r_asm      <= 32'd0;
            r_fmt_seen <= 1'b0;
        end else if (fire) begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_tag      <= n_tag;
            r_cr       <= n_cr;
            r_fmt      <= n_fmt;
            r_ch       <= n_ch;
            r_rate     <= n_rate;
            r_bits     <= n_bits;
            r_asm      <= n_asm;
            r_fmt_seen <= n_fmt_seen;
        end
    end

endmodule

`default_nettype wire

// File: src/wsp_out_reg.sv
// ----------------------------------------------------------------------------
// wsp_out_reg
// Result register: holds one result until the receiver takes the transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsp_out_reg
    import wsp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_out_item i_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item
);

    logic      r_valid;
    t_out_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: src/wav_stream_parser.sv
// ----------------------------------------------------------------------------
// wav_stream_parser
// Byte-serial RIFF/WAVE parser: reports the fmt chunk and streams samples.
//
// Input channel: one file byte per transfer with a flag on the last byte of
// the file. Output channel: at most one result per byte (format report,
// sample, empty data chunk or error), all fields in one struct.
// Throughput is one byte per cycle while the receiver does not stall; the
// parser state is updated by a single level of next-state logic between the
// input register and the result register, which each byte passes in turn.
// When the receiver stalls, the result register holds and the parser stops;
// the input register keeps its byte, so the input ready drops as soon as the
// input register is full (at once when bytes arrive back to back) and stays
// low until the result transfer completes.
// Reset returns the parser to the RIFF tag and loads the default format
// (PCM, one channel, 44100 Hz, 16 bits); both registers come up empty.
// A byte flagged as last restarts the parser but keeps the stored format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wav_stream_parser
    import wsp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    logic      in_valid;
    logic      core_ready;
    t_in_item  in_item;
    logic      res_valid;
    logic      res_ready;
    t_out_item res_item;

    wsp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (in_valid),
        .i_ready (core_ready),
        .o_item  (in_item)
    );

    wsp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .o_ready     (core_ready),
        .i_item      (in_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res_item)
    );

    wsp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_item  (res_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire
